// ===== src/minhash_signature_generator_assert.svh =====
// Assertion macros for the minhash signature generator.
// Depends on nothing; included by the top level, which asserts.
`ifndef MINHASH_SIGNATURE_GENERATOR_ASSERT_SVH
`define MINHASH_SIGNATURE_GENERATOR_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define MHSG_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("%m: same-cycle check failed");

// Condition a implies condition b in the next cycle.
`define MHSG_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== src/mhsg_pkg.sv =====
// Shared types and constants for the minhash signature generator.
// No dependencies; imported by mhsg_hash_pipe and the top level.
`default_nettype none

package mhsg_pkg;

  localparam int HASH_W       = 32;
  localparam int COUNT_W      = 7;
  localparam int FUNC_W       = 6;
  localparam int CFG_INDEX_W  = 2;
  localparam int MH_MAX_HASHES = 64;

  localparam logic [HASH_W-1:0] MIX1_MULT = 32'h045d_9f3b;
  localparam logic [HASH_W-1:0] MIX2_MULT = 32'h27d4_eb2d;
  localparam logic [HASH_W-1:0] MIX2_XOR  = 32'd61;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SEED       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT = 2'd1;

  // Pair of base hashes handed from the hash pipe to the expander
  typedef struct packed {
    logic [HASH_W-1:0] h1;
    logic [HASH_W-1:0] h2;
  } mhsg_hash_t;

endpackage

`default_nettype wire

// ===== src/mhsg_hash_pipe.sv =====
// Three-stage pipeline: key forming, then both 32-bit integer mixers.
// Depends on mhsg_pkg.
`default_nettype none

module mhsg_hash_pipe
  import mhsg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [HASH_W-1:0] seed,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [HASH_W-1:0] shingle_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mhsg_hash_t             out_hash
);

  logic              v1, v2, v3;
  logic              ready1, ready2, ready3;
  logic [HASH_W-1:0] key;
  logic [HASH_W-1:0] m1a, w2;
  logic [HASH_W-1:0] m1b, w3;

  logic [HASH_W-1:0] key_x, w_t, w_u;

  always_comb begin
    ready3 = !v3 || out_ready;
    ready2 = !v2 || ready3;
    ready1 = !v1 || ready2;
  end

  assign in_ready = ready1;

  always_comb begin
    key_x = (key >> 16) ^ key;
    w_t   = (key ^ MIX2_XOR) ^ (key >> 16);
    w_u   = w_t + (w_t << 3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      key <= shingle_index + HASH_W'(1) + seed;
    end
    if (ready2 && v1) begin
      m1a <= key_x * MIX1_MULT;
      w2  <= w_u ^ (w_u >> 4);
    end
    if (ready3 && v2) begin
      m1b <= ((m1a >> 16) ^ m1a) * MIX1_MULT;
      w3  <= w2 * MIX2_MULT;
    end
  end

  assign out_valid   = v3;
  assign out_hash.h1 = (m1b >> 16) ^ m1b;
  assign out_hash.h2 = w3 ^ (w3 >> 15);

endmodule

`default_nettype wire

// ===== src/minhash_signature_generator.sv =====
// MinHash signature generator. Each shingle_index transfer yields the effective
// hash count (hash_count, with 0 read as 1 and values above MAX_HASHES read as
// MAX_HASHES) result transfers, one per cycle while out_stall is low,
// function_index 0 upward and last on the final one. The first result passes
// through the key register, the two multiplier stages of the mixers and then
// the expander's output register before it is presented. The three-stage hash pipe
// takes inputs every cycle until it fills; sustained, the single expander output
// register sets the pace: it takes the next item only as the last result of the
// current one transfers, and it steps h1 + (j+1)*h2 + j*j by adding h2 + 2j + 1.
// Depends on mhsg_pkg, mhsg_hash_pipe and the assertion macro header.
`default_nettype none

`include "minhash_signature_generator_assert.svh"

module minhash_signature_generator
  import mhsg_pkg::*;
#(
  parameter int MAX_HASHES = MH_MAX_HASHES
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [HASH_W-1:0]      cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [HASH_W-1:0]      shingle_index,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [HASH_W-1:0]           hash_value,
  output logic [FUNC_W-1:0]           function_index,
  output logic                        last
);

  logic [HASH_W-1:0]  seed;
  logic [COUNT_W-1:0] hash_count;
  logic [COUNT_W-1:0] n_eff;

  logic               pipe_in_ready;
  logic               pipe_valid;
  logic               pipe_ready;
  mhsg_hash_t         pipe_hash;

  logic               busy;
  logic [HASH_W-1:0]  acc;
  logic [HASH_W-1:0]  h2;
  logic [FUNC_W-1:0]  j;
  logic               is_last;

  logic               out_xfer;
  logic               load;
  logic [COUNT_W-1:0] j_wide;
  logic [HASH_W-1:0]  odd_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= '0;
      hash_count <= COUNT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEED:       seed       <= cfg_data;
        REG_HASH_COUNT: hash_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (hash_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (hash_count > COUNT_W'(MAX_HASHES)) begin
      n_eff = COUNT_W'(MAX_HASHES);
    end else begin
      n_eff = hash_count;
    end
  end

  mhsg_hash_pipe u_hash_pipe (
    .clk           (clk),
    .rst           (rst),
    .seed          (seed),
    .in_valid      (in_valid),
    .in_ready      (pipe_in_ready),
    .shingle_index (shingle_index),
    .out_valid     (pipe_valid),
    .out_ready     (pipe_ready),
    .out_hash      (pipe_hash)
  );

  assign in_stall = !pipe_in_ready;

  always_comb begin
    out_xfer   = busy && !out_stall;
    pipe_ready = !busy || (out_xfer && is_last);
    load       = pipe_ready && pipe_valid;
    j_wide     = {1'b0, j};
    // 2j + 1 for the step from j to j + 1
    odd_step   = HASH_W'({j_wide[COUNT_W-2:0], 1'b1});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (out_xfer && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc     <= pipe_hash.h1 + pipe_hash.h2;
      h2      <= pipe_hash.h2;
      j       <= '0;
      is_last <= (n_eff == COUNT_W'(1));
    end else if (out_xfer) begin
      // advance to the next derived function
      acc     <= acc + h2 + odd_step;
      j       <= j + FUNC_W'(1);
      is_last <= ((j_wide + COUNT_W'(2)) == n_eff);
    end
  end

  assign out_valid      = busy;
  assign hash_value     = acc;
  assign function_index = j;
  assign last           = is_last;

  `MHSG_ASSERT_SAME(a_last_at_count, clk, rst, out_valid && last,
                    ({1'b0, function_index} + COUNT_W'(1)) == n_eff)
  `MHSG_ASSERT_SAME(a_index_in_range, clk, rst, out_valid,
                    ({1'b0, function_index} < n_eff))
  `MHSG_ASSERT_NEXT(a_index_steps, clk, rst, out_valid && !out_stall && !last,
                    out_valid && (function_index == $past(function_index) + FUNC_W'(1)))

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for minhash_signature_generator: random and directed
// shingle transfers, predicted double-hash signatures checked per result word.
// Depends on mhsg_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb;
  import mhsg_pkg::*;

  localparam int MAX_FUNCS   = MH_MAX_HASHES;
  localparam int SETTLE_CYC  = 8;
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 5000;

  // Mixer constants, kept local so the predictor stands apart from the RTL
  localparam logic [31:0] FOLD_MULT = 32'h045d_9f3b;
  localparam logic [31:0] WANG_MULT = 32'h27d4_eb2d;
  localparam logic [31:0] WANG_XOR  = 32'd61;

  // Indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [FUNC_W-1:0] func;
    logic              is_last;
  } signature_word_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [HASH_W-1:0]      cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [HASH_W-1:0]      shingle_index = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [HASH_W-1:0]      hash_value;
  logic [FUNC_W-1:0]      function_index;
  logic                   last;

  logic [HASH_W-1:0]      pending_shingles[$];
  signature_word_t        expected_hashes[$];

  // Shadow registers
  logic [HASH_W-1:0]      key_seed = '0;
  logic [COUNT_W-1:0]     fan_out = 7'd1;

  int send_idle_pct = 36;
  int recv_idle_pct = 36;
  bit hold_armed = 1'b0;
  bit hold_started = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int errors = 0;

  minhash_signature_generator DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .shingle_index  (shingle_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hash_value     (hash_value),
    .function_index (function_index),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] fold_mix(input logic [31:0] x);
    x = ((x >> 16) ^ x) * FOLD_MULT;
    x = ((x >> 16) ^ x) * FOLD_MULT;
    return (x >> 16) ^ x;
  endfunction

  function automatic logic [31:0] wang_mix(input logic [31:0] x);
    x = (x ^ WANG_XOR) ^ (x >> 16);
    x = x + (x << 3);
    x = x ^ (x >> 4);
    x = x * WANG_MULT;
    return x ^ (x >> 15);
  endfunction

  function automatic void predict_signature(input logic [HASH_W-1:0] idx);
    logic [31:0] key, h1, h2, j, n;
    signature_word_t w;
    key = idx + 32'd1 + key_seed;
    h1 = fold_mix(key);
    h2 = wang_mix(key);
    // zero reads as one, above the maximum saturates
    if (fan_out == '0) begin
      n = 32'd1;
    end else if (fan_out > MAX_FUNCS) begin
      n = MAX_FUNCS;
    end else begin
      n = 32'(fan_out);
    end
    for (j = 0; j < n; j++) begin
      w.hash    = h1 + (j + 32'd1) * h2 + j * j;
      w.func    = j[FUNC_W-1:0];
      w.is_last = (j + 32'd1 == n);
      expected_hashes.push_back(w);
    end
  endfunction

  // Sender: hold the payload while stalled, advance on transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_signature(shingle_index);
      end
      if (!in_valid || !in_stall) begin
        if (pending_shingles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid      <= 1'b1;
          shingle_index <= pending_shingles.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    signature_word_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: unexpected result hash_value %08h function_index %0d last %0b",
                   $time, hash_value, function_index, last);
          errors++;
        end else begin
          e = expected_hashes.pop_front();
          if (hash_value !== e.hash) begin
            $display("%0t: hash_value expected %08h got %08h", $time, e.hash, hash_value);
            errors++;
          end
          if (function_index !== e.func) begin
            $display("%0t: function_index expected %0d got %0d",
                     $time, e.func, function_index);
            errors++;
          end
          if (last !== e.is_last) begin
            $display("%0t: last expected %0b got %0b", $time, e.is_last, last);
            errors++;
          end
        end
      end
      if (hold_armed && !hold_started) begin
        hold_started = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("** minhash_signature_generator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [HASH_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SEED:       key_seed = data;
      REG_HASH_COUNT: fan_out = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic offer(input logic [HASH_W-1:0] idx);
    pending_shingles.push_back(idx);
  endtask

  // Wait until every prediction has been matched, then let the pipe drain
  task automatic settle();
    do @(posedge clk);
    while (pending_shingles.size() != 0 || in_valid || expected_hashes.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    int p, k;
    logic [COUNT_W-1:0] count;
    logic [HASH_W-1:0]  s, v;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, field extremes
    offer('0);
    offer('1);
    offer(32'hFFFF_FFFE);
    offer(32'hAAAA_AAAA);
    offer(32'h5555_5555);
    settle();

    // Writes to spare indexes must leave both registers alone
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, '1);
    offer(32'd1);
    offer(32'h8000_0000);
    settle();

    // Key wrap with a full seed, zero count
    write_reg(REG_SEED, '1);
    write_reg(REG_HASH_COUNT, '0);
    offer('0);
    offer('1);
    offer(32'd1);
    settle();

    write_reg(REG_SEED, '0);
    write_reg(REG_HASH_COUNT, 32'd127);
    offer(32'h1234_5678);
    offer('1);
    settle();

    write_reg(REG_HASH_COUNT, 32'd65);
    offer(32'h0000_FFFF);
    settle();

    // Upper data bits are dropped: low seven bits give the maximum count
    write_reg(REG_HASH_COUNT, 32'hFFFF_FF40);
    offer(32'hFFFF_0000);
    settle();

    write_reg(REG_HASH_COUNT, 32'd2);
    offer(32'h7FFF_FFFF);
    offer('0);
    settle();

    for (p = 0; p < 12; p++) begin
      send_idle_pct = (p == 3 || p == 7) ? 0 : 36;
      recv_idle_pct = (p == 3) ? 0 : 36;
      case (p % 4)
        1:       s = '1;
        2:       s = '0;
        default: s = $urandom;
      endcase
      write_reg(REG_SEED, s);
      count = COUNT_W'((p % 2 == 0) ? $urandom_range(1, 8) : $urandom_range(0, 127));
      if (p == 5) begin
        count = COUNT_W'(MAX_FUNCS);
      end
      v = $urandom;
      v[COUNT_W-1:0] = count;
      write_reg(REG_HASH_COUNT, v);
      // Long receiver hold while the sender keeps offering
      if (p == 7) begin
        hold_armed = 1'b1;
      end
      for (k = 0; k < 34; k++) begin
        case ($urandom_range(0, 7))
          0:       v = $urandom_range(0, 3);
          1:       v = '1 - $urandom_range(0, 3);
          2:       v = ~s - $urandom_range(0, 2);
          default: v = $urandom;
        endcase
        offer(v);
      end
      settle();
    end

    repeat (16) @(posedge clk);
    if (errors == 0 && expected_hashes.size() == 0) begin
      $display("** minhash_signature_generator: PASSED **");
    end else begin
      $display("** minhash_signature_generator: FAILED **");
    end
    $finish;
  end

endmodule
